// File: rtl/tfn_pkg.sv
// Shared constants and types for the triangle face normal pipeline.
package tfn_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int FIELD_W        = 16;
  localparam int OUT_W          = 16;
  localparam int NUM_VTX_FIELDS = 9;
  localparam int MAGS_W         = 31;
  localparam int SQ_W           = 2 * MAGS_W;
  localparam int SUM_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int ROOT_STEPS     = 32;

  // Control that travels beside the data from the prep stages through the divider
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

endpackage

// File: rtl/tfn_cross.sv
// Edge vectors and cross product, three register stages.
module tfn_cross #(
  parameter int CB = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [tfn_pkg::FIELD_W-1:0]  vtx [tfn_pkg::NUM_VTX_FIELDS],
  output logic                         n_valid,
  output logic signed [2*CB+2:0]       n [3]
);

  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;

  logic signed [CB-1:0]             co [tfn_pkg::NUM_VTX_FIELDS];
  logic [CB+tfn_pkg::FIELD_W-1:0]   wide [tfn_pkg::NUM_VTX_FIELDS];
  logic signed [EW-1:0]             e1_nxt [3];
  logic signed [EW-1:0]             e2_nxt [3];
  logic signed [EW-1:0]             e1_r [3];
  logic signed [EW-1:0]             e2_r [3];
  logic signed [PW-1:0]             p_r [6];
  logic signed [NW-1:0]             n_r [3];
  logic                             v1_r, v2_r, v3_r;

  // Keep the low CB bits of each coordinate, sign-extended
  always_comb begin
    for (int k = 0; k < tfn_pkg::NUM_VTX_FIELDS; k++) begin
      wide[k] = {{CB{1'b0}}, vtx[k]};
      co[k]   = $signed(wide[k][CB-1:0]);
    end
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = EW'(co[3+k]) - EW'(co[k]);
      e2_nxt[k] = EW'(co[6+k]) - EW'(co[k]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Register edges, partial products, then the cross components
  always_ff @(posedge clk) begin
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    p_r[0] <= e2_r[1] * e1_r[2];
    p_r[1] <= e2_r[2] * e1_r[1];
    p_r[2] <= e2_r[2] * e1_r[0];
    p_r[3] <= e2_r[0] * e1_r[2];
    p_r[4] <= e2_r[0] * e1_r[1];
    p_r[5] <= e2_r[1] * e1_r[0];
    n_r[0] <= NW'(p_r[0]) - NW'(p_r[1]);
    n_r[1] <= NW'(p_r[2]) - NW'(p_r[3]);
    n_r[2] <= NW'(p_r[4]) - NW'(p_r[5]);
  end

  assign n_valid = v3_r;
  assign n       = n_r;

endmodule

// File: rtl/tfn_prep.sv
// Magnitudes, range shift, squares and sum of squares, five register stages.
module tfn_prep #(
  parameter int CB = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          n_valid,
  input  logic signed [2*CB+2:0]        n [3],
  output tfn_pkg::ctl_t                 ctl_out,
  output logic [tfn_pkg::MAGS_W-1:0]    mags_out [3],
  output logic [tfn_pkg::SUM_W-1:0]     sum_out
);

  localparam int MW = 2 * CB + 3;
  localparam int SW = $clog2(MW + 1);

  tfn_pkg::ctl_t                  ca_r, cb_r, cc_r, cd_r, ce_r;
  tfn_pkg::ctl_t                  ca_nxt;
  logic [MW-1:0]                  mag_nxt [3];
  logic [MW-1:0]                  mag_r [3];
  logic [MW-1:0]                  magb_r [3];
  logic [MW-1:0]                  mx;
  logic [SW-1:0]                  blen;
  logic [SW-1:0]                  s_nxt, s_r;
  logic [tfn_pkg::MAGS_W-1:0]     sh_r [3];
  logic [tfn_pkg::MAGS_W-1:0]     shd_r [3];
  logic [tfn_pkg::MAGS_W-1:0]     she_r [3];
  logic [tfn_pkg::SQ_W-1:0]       sq_r [3];
  logic [tfn_pkg::SUM_W-1:0]      sum_r;

  // Split each component into sign and magnitude
  always_comb begin
    ca_nxt.valid = n_valid;
    for (int k = 0; k < 3; k++) begin
      ca_nxt.neg[k] = n[k][MW-1];
      mag_nxt[k]    = n[k][MW-1] ? MW'(-n[k]) : MW'(n[k]);
    end
    ca_nxt.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end

  // Find the shift that brings the largest magnitude under 2^31
  always_comb begin
    mx = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    if (mag_r[2] > mx) begin
      mx = mag_r[2];
    end
    blen = '0;
    for (int b = 0; b < MW; b++) begin
      if (mx[b]) begin
        blen = SW'(b + 1);
      end
    end
    s_nxt = (blen > SW'(tfn_pkg::MAGS_W)) ? blen - SW'(tfn_pkg::MAGS_W) : '0;
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      cb_r <= '0;
      cc_r <= '0;
      cd_r <= '0;
      ce_r <= '0;
    end else begin
      ca_r <= ca_nxt;
      cb_r <= ca_r;
      cc_r <= cb_r;
      cd_r <= cc_r;
      ce_r <= cd_r;
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    magb_r <= mag_r;
    s_r    <= s_nxt;
    for (int k = 0; k < 3; k++) begin
      sh_r[k] <= tfn_pkg::MAGS_W'(magb_r[k] >> s_r);
      sq_r[k] <= sh_r[k] * sh_r[k];
    end
    shd_r <= sh_r;
    she_r <= shd_r;
    sum_r <= tfn_pkg::SUM_W'(sq_r[0]) + tfn_pkg::SUM_W'(sq_r[1])
           + tfn_pkg::SUM_W'(sq_r[2]);
  end

  assign ctl_out  = ce_r;
  assign mags_out = she_r;
  assign sum_out  = sum_r;

endmodule

// File: rtl/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfn_pkg::ctl_t                 ctl_in,
  input  logic [tfn_pkg::MAGS_W-1:0]    mags_in [3],
  input  logic [tfn_pkg::SUM_W-1:0]     sum_in,
  output tfn_pkg::ctl_t                 ctl_out,
  output logic [tfn_pkg::MAGS_W-1:0]    mags_out [3],
  output logic [tfn_pkg::ROOT_W-1:0]    root_out
);

  localparam int NS = tfn_pkg::ROOT_STEPS;
  localparam int XW = tfn_pkg::SUM_W;

  logic [XW-1:0]                x_pipe [NS+1];
  logic [XW-1:0]                res_pipe [NS+1];
  tfn_pkg::ctl_t                ctl_pipe [NS+1];
  logic [tfn_pkg::MAGS_W-1:0]   mg_pipe [NS+1][3];

  assign x_pipe[0]   = sum_in;
  assign res_pipe[0] = '0;
  assign ctl_pipe[0] = ctl_in;
  assign mg_pipe[0]  = mags_in;

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * k);
    logic [XW-1:0] trial;
    logic [XW-1:0] x_nxt, res_nxt;

    // Try to subtract the next root bit
    always_comb begin
      trial = res_pipe[k] + BIT;
      if (x_pipe[k] >= trial) begin
        x_nxt   = x_pipe[k] - trial;
        res_nxt = (res_pipe[k] >> 1) + BIT;
      end else begin
        x_nxt   = x_pipe[k];
        res_nxt = res_pipe[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_pipe[k+1] <= '0;
      end else begin
        ctl_pipe[k+1] <= ctl_pipe[k];
      end
    end

    always_ff @(posedge clk) begin
      x_pipe[k+1]   <= x_nxt;
      res_pipe[k+1] <= res_nxt;
      mg_pipe[k+1]  <= mg_pipe[k];
    end
  end

  assign ctl_out  = ctl_pipe[NS];
  assign mags_out = mg_pipe[NS];
  assign root_out = res_pipe[NS][tfn_pkg::ROOT_W-1:0];

endmodule

// File: rtl/tfn_div.sv
// Rounded division of each magnitude by the length, one quotient bit per stage.
module tfn_div #(
  parameter int FB = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfn_pkg::ctl_t                 ctl_in,
  input  logic [tfn_pkg::MAGS_W-1:0]    mags_in [3],
  input  logic [tfn_pkg::ROOT_W-1:0]    root_in,
  output logic                          out_valid,
  output logic [tfn_pkg::OUT_W-1:0]     norm [3],
  output logic                          degen
);

  localparam int RW = tfn_pkg::ROOT_W + FB + 1;
  localparam int QW = FB + 1;
  localparam int TW = QW + tfn_pkg::OUT_W;
  localparam int NS = FB + 1;

  logic [tfn_pkg::ROOT_W-1:0]   len_nxt;
  logic [RW-1:0]                r_pipe [NS+1][3];
  logic [QW-1:0]                q_pipe [NS+1][3];
  logic [tfn_pkg::ROOT_W-1:0]   len_pipe [NS+1];
  tfn_pkg::ctl_t                ctl_pipe [NS+1];
  logic [TW-1:0]                t_mag [3];
  logic [TW-1:0]                t_sgn [3];
  logic [tfn_pkg::OUT_W-1:0]    norm_r [3];
  logic                         degen_r, valid_r;

  assign len_nxt = (root_in == '0) ? tfn_pkg::ROOT_W'(1) : root_in;

  // Load the rounded dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_pipe[0] <= '0;
    end else begin
      ctl_pipe[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    len_pipe[0] <= len_nxt;
    for (int k = 0; k < 3; k++) begin
      r_pipe[0][k] <= (RW'(mags_in[k]) << FB) + RW'(len_nxt >> 1);
      q_pipe[0][k] <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int SH = FB - j;
    logic [RW-1:0] dsr;
    logic [RW-1:0] r_nxt [3];
    logic [QW-1:0] q_nxt [3];

    // Subtract the shifted divisor where it fits
    always_comb begin
      dsr = RW'(len_pipe[j]) << SH;
      for (int k = 0; k < 3; k++) begin
        if (r_pipe[j][k] >= dsr) begin
          r_nxt[k] = r_pipe[j][k] - dsr;
          q_nxt[k] = {q_pipe[j][k][QW-2:0], 1'b1};
        end else begin
          r_nxt[k] = r_pipe[j][k];
          q_nxt[k] = {q_pipe[j][k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_pipe[j+1] <= '0;
      end else begin
        ctl_pipe[j+1] <= ctl_pipe[j];
      end
    end

    always_ff @(posedge clk) begin
      r_pipe[j+1]   <= r_nxt;
      q_pipe[j+1]   <= q_nxt;
      len_pipe[j+1] <= len_pipe[j];
    end
  end

  // Saturate, apply sign, drop to the field width
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_mag[k] = (q_pipe[NS][k] > (QW'(1) << FB)) ? (TW'(1) << FB) : TW'(q_pipe[NS][k]);
      t_sgn[k] = ctl_pipe[NS].neg[k] ? -t_mag[k] : t_mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_pipe[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    degen_r <= ctl_pipe[NS].degen;
    for (int k = 0; k < 3; k++) begin
      norm_r[k] <= ctl_pipe[NS].degen ? '0 : t_sgn[k][tfn_pkg::OUT_W-1:0];
    end
  end

  assign out_valid = valid_r;
  assign norm      = norm_r;
  assign degen     = degen_r;

endmodule

// File: rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Pipeline length is dominated by the 32-stage square root and the FRAC_BITS + 1 stage divider.
// Reset (synchronous, active low) clears all valid bits; data registers keep garbage.
// Results appear for one cycle on out_valid; the receiver cannot hold them off.
module triangle_face_normal #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_a_x,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_a_y,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_a_z,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_b_x,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_b_y,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_b_z,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_c_x,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_c_y,
  input  logic [tfn_pkg::FIELD_W-1:0]  in_c_z,
  output logic                         out_valid,
  output logic [tfn_pkg::OUT_W-1:0]    out_norm_x,
  output logic [tfn_pkg::OUT_W-1:0]    out_norm_y,
  output logic [tfn_pkg::OUT_W-1:0]    out_norm_z,
  output logic                         out_degenerate
);

  localparam int LAT = FRAC_BITS + 43;

  logic [tfn_pkg::FIELD_W-1:0]   vtx [tfn_pkg::NUM_VTX_FIELDS];
  logic                          n_valid;
  logic signed [2*COORD_BITS+2:0] n [3];
  tfn_pkg::ctl_t                 ctl_p, ctl_s;
  logic [tfn_pkg::MAGS_W-1:0]    mags_p [3];
  logic [tfn_pkg::MAGS_W-1:0]    mags_s [3];
  logic [tfn_pkg::SUM_W-1:0]     sum;
  logic [tfn_pkg::ROOT_W-1:0]    root;
  logic [tfn_pkg::OUT_W-1:0]     norm [3];
  logic                          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign vtx[0] = in_a_x;
  assign vtx[1] = in_a_y;
  assign vtx[2] = in_a_z;
  assign vtx[3] = in_b_x;
  assign vtx[4] = in_b_y;
  assign vtx[5] = in_b_z;
  assign vtx[6] = in_c_x;
  assign vtx[7] = in_c_y;
  assign vtx[8] = in_c_z;

  tfn_cross #(.CB(COORD_BITS)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .vtx      (vtx),
    .n_valid  (n_valid),
    .n        (n)
  );

  tfn_prep #(.CB(COORD_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .n_valid  (n_valid),
    .n        (n),
    .ctl_out  (ctl_p),
    .mags_out (mags_p),
    .sum_out  (sum)
  );

  tfn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_p),
    .mags_in  (mags_p),
    .sum_in   (sum),
    .ctl_out  (ctl_s),
    .mags_out (mags_s),
    .root_out (root)
  );

  tfn_div #(.FB(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_s),
    .mags_in   (mags_s),
    .root_in   (root),
    .out_valid (out_valid),
    .norm      (norm),
    .degen     (out_degenerate)
  );

  assign out_norm_x = norm[0];
  assign out_norm_y = norm[1];
  assign out_norm_z = norm[2];

  // Every result traces back to a matching earlier request
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && rst_n, LAT))
    else $error("result without matching request");

  // Every request yields a result
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && rst_n, LAT) |-> out_valid)
    else $error("request lost in pipeline");

  // Degenerate results carry a zero vector
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0))
    else $error("degenerate result with nonzero normal");

endmodule

// File: tb/sv/tb_triangle_face_normal.sv
// Self-checking testbench for the triangle face normal pipeline.
module tb_triangle_face_normal;

  localparam int CBITS     = tfn_pkg::COORD_BITS_DEF;
  localparam int FBITS     = tfn_pkg::FRAC_BITS_DEF;
  localparam int NVF       = tfn_pkg::NUM_VTX_FIELDS;
  localparam int OW        = tfn_pkg::OUT_W;
  localparam int LATENCY   = FBITS + 43;
  localparam int WDOG_MAX  = 20000;
  localparam int NUM_RAND  = 1250;

  typedef logic [tfn_pkg::FIELD_W-1:0] coord_t;
  typedef coord_t tri_t [NVF];

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          degen;
  } normal_t;

  typedef struct {
    tri_t    vtx;
    logic    has_exp;
    normal_t exp_n;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_f [NVF] = '{default: '0};
  logic out_valid;
  logic [OW-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_degenerate;

  normal_t pending_normals [$];
  logic failed = 1'b0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  always #5 clk = ~clk;

  triangle_face_normal dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_f[0]), .in_a_y(in_f[1]), .in_a_z(in_f[2]),
    .in_b_x(in_f[3]), .in_b_y(in_f[4]), .in_b_z(in_f[5]),
    .in_c_x(in_f[6]), .in_c_y(in_f[7]), .in_c_z(in_f[8]),
    .out_valid(out_valid), .out_norm_x(out_norm_x), .out_norm_y(out_norm_y),
    .out_norm_z(out_norm_z), .out_degenerate(out_degenerate)
  );

  // Sign-extend one coordinate from its used width
  function automatic longint sext_coord(coord_t v);
    logic [CBITS-1:0] low;
    low = v[CBITS-1:0];
    return longint'(signed'(low));
  endfunction

  // Floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= root + bit_v) begin
        x -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  // Compute the unit face normal of one triangle
  function automatic normal_t face_normal(tri_t t);
    longint p [NVF];
    longint e1 [3], e2 [3], cr [3];
    logic [63:0] mag [3];
    logic [63:0] mx, sum, len, q;
    logic [OW-1:0] comp [3];
    normal_t r;
    int sh;
    for (int i = 0; i < NVF; i++) p[i] = sext_coord(t[i]);
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[i];
    end
    cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
    cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
    cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 31)) sh++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FBITS) + (len >> 1)) / len;
      if (q > (64'd1 << FBITS)) q = 64'd1 << FBITS;
      if (cr[i] < 0) q = -q;
      comp[i] = q[OW-1:0];
    end
    r.nx = comp[0];
    r.ny = comp[1];
    r.nz = comp[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // Drive one request and hold until accepted
  task automatic send_triangle(tri_t t, logic has_exp, normal_t exp_n);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    for (int i = 0; i < NVF; i++) in_f[i] <= t[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_normals.push_back(has_exp ? exp_n : face_normal(t));
  endtask

  function automatic tri_t rand_triangle(int mode);
    tri_t t;
    for (int i = 0; i < NVF; i++) begin
      case (mode)
        0: t[i] = coord_t'($urandom);
        1: t[i] = coord_t'($urandom_range(0, 15) - 8);
        2: t[i] = $urandom_range(1) ? 16'h8000 + coord_t'($urandom_range(3))
                                    : 16'h7fff - coord_t'($urandom_range(3));
        default: t[i] = coord_t'($urandom_range(0, 2047) - 1024);
      endcase
    end
    // Sometimes repeat a vertex so the triangle is degenerate
    if ($urandom_range(19) == 0)
      for (int i = 0; i < 3; i++) t[6+i] = t[3+i];
    return t;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time,
                 out_norm_x, out_norm_y, out_norm_z, out_degenerate);
        failed <= 1'b1;
      end else begin
        normal_t e;
        e = pending_normals.pop_front();
        if (e.nx !== out_norm_x || e.ny !== out_norm_y || e.nz !== out_norm_z ||
            e.degen !== out_degenerate) begin
          $display("%0t: expected %h %h %h %b, got %h %h %h %b", $time,
                   e.nx, e.ny, e.nz, e.degen,
                   out_norm_x, out_norm_y, out_norm_z, out_degenerate);
          failed <= 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with nothing accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    normal_t no_exp, dg;
    int drain;
    dg = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    no_exp = '0;
    // Degenerate: all vertices equal, collinear, extremes equal
    dir_rows.push_back('{'{default: 16'h0}, 1'b1, dg});
    dir_rows.push_back('{'{default: 16'h7fff}, 1'b1, dg});
    dir_rows.push_back('{'{default: 16'h8000}, 1'b1, dg});
    dir_rows.push_back('{'{16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2,
                         16'd3, 16'd3, 16'd3}, 1'b1, dg});
    // Axis-aligned: e1 = x, e2 = y gives n = -z; swapped gives n = +z
    dir_rows.push_back('{'{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0,
                         16'd0, 16'd1, 16'd0}, 1'b1,
                         '{nx: '0, ny: '0, nz: 16'hc000, degen: 1'b0}});
    dir_rows.push_back('{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0,
                         16'd1, 16'd0, 16'd0}, 1'b1,
                         '{nx: '0, ny: '0, nz: 16'h4000, degen: 1'b0}});
    // Extremes of the coordinate range and mixed patterns
    dir_rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                         16'h8000, 16'h7fff, 16'h8000}, 1'b0, no_exp});
    dir_rows.push_back('{'{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                         16'h8000, 16'h8000, 16'h7fff}, 1'b0, no_exp});
    dir_rows.push_back('{'{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                         16'h7fff, 16'h7fff, 16'h8000}, 1'b0, no_exp});
    dir_rows.push_back('{'{16'hffff, 16'h0001, 16'h0000, 16'h0001, 16'hffff, 16'h0000,
                         16'h0000, 16'h0000, 16'h7fff}, 1'b0, no_exp});
    dir_rows.push_back('{'{16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f,
                         16'hf0f0, 16'h3333, 16'hcccc, 16'h0001}, 1'b0, no_exp});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table without gaps
    foreach (dir_rows[k]) send_triangle(dir_rows[k].vtx, dir_rows[k].has_exp,
                                        dir_rows[k].exp_n);

    // Random requests in idling phases
    for (int n = 0; n < NUM_RAND; n++) begin
      case ((n / 125) % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 81;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 26;
      endcase
      send_triangle(rand_triangle($urandom_range(4)), 1'b0, no_exp);
    end
    start <= 1'b0;

    // Drain the pipeline
    drain = 0;
    while (pending_normals.size() != 0 && drain < 4 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY) @(posedge clk);
    if (!failed && pending_normals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
